FILE: rtl/ipdc_pkg.sv
// ----------------------------------------------------------------------------
// ipdc_pkg
// Types and fixed codes shared by the PIO disk controller files.
// ----------------------------------------------------------------------------
package ipdc_pkg;

	typedef enum logic [1:0] {
		DOP_NONE  = 2'd0,
		DOP_READ  = 2'd1,
		DOP_WRITE = 2'd2
	} disk_op_t;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_DIRECTION = 3'd1,
		ERR_ACCESS    = 3'd2,
		ERR_COMMAND   = 3'd3,
		ERR_PAST_END  = 3'd4
	} err_t;

	localparam logic       BUS_READ  = 1'b0;
	localparam logic       BUS_WRITE = 1'b1;

	localparam logic [2:0] PORT_DATA  = 3'd0;
	localparam logic [2:0] PORT_COUNT = 3'd2;
	localparam logic [2:0] PORT_LBA0  = 3'd3;
	localparam logic [2:0] PORT_LBA3  = 3'd6;
	localparam logic [2:0] PORT_CMD   = 3'd7;

	localparam logic [2:0] SIZE_BYTE = 3'd1;
	localparam logic [2:0] SIZE_WORD = 3'd4;

	localparam logic [7:0] ST_READY  = 8'h40;
	localparam logic [7:0] CMD_READ  = 8'h20;
	localparam logic [7:0] CMD_WRITE = 8'h30;
	localparam logic [7:0] TOP_MASK  = 8'h1f;

	typedef struct packed {
		logic        cmd;
		logic [2:0]  offset;
		logic [2:0]  access_size;
		logic [31:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		disk_op_t    disk_op;
		logic [31:0] disk_addr;
		logic [31:0] disk_wdata;
		logic        irq;
		err_t        error;
	} out_item_t;

endpackage

FILE: rtl/ipdc_chan_if.sv
// ----------------------------------------------------------------------------
// ipdc_chan_if
// Valid/ready channel that carries one item of the given payload type.
// ----------------------------------------------------------------------------
interface ipdc_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/ipdc_access.sv
// ----------------------------------------------------------------------------
// ipdc_access
// Decode of one bus access: result item and next controller state.
// ----------------------------------------------------------------------------
module ipdc_access #(
	parameter int SECTOR_BYTES = 512,
	parameter int CW           = $clog2(SECTOR_BYTES + 4)
) (
	input  ipdc_pkg::in_item_t  item,
	input  logic [3:0][7:0]     lba_q,
	input  logic [7:0]          status_q,
	input  logic                write_mode_q,
	input  logic [CW-1:0]       byte_count_q,
	input  logic [31:0]         sector_base_q,
	output ipdc_pkg::out_item_t res,
	output logic [3:0][7:0]     lba_d,
	output logic [7:0]          status_d,
	output logic                write_mode_d,
	output logic [CW-1:0]       byte_count_d,
	output logic [31:0]         sector_base_d
);
	import ipdc_pkg::*;

	localparam logic [CW-1:0] SectorEnd = CW'(SECTOR_BYTES);
	localparam logic [CW-1:0] WordBytes = CW'(4);
	localparam logic [31:0]   SectorMul = 32'(SECTOR_BYTES);

	logic [31:0]   sector;
	logic [CW-1:0] count_next;
	logic [7:0]    code;

	always_comb begin
		sector = {3'b000, lba_q[3][4:0] & TOP_MASK[4:0], lba_q[2], lba_q[1], lba_q[0]};
		count_next = byte_count_q + WordBytes;
		code = item.write_data[7:0];

		lba_d = lba_q;
		status_d = status_q;
		write_mode_d = write_mode_q;
		byte_count_d = byte_count_q;
		sector_base_d = sector_base_q;
		res = '0;

		if (item.offset == PORT_DATA && item.access_size == SIZE_WORD) begin
			if (item.cmd != write_mode_q) begin
				res.error = ERR_DIRECTION;
			end else if (byte_count_q >= SectorEnd) begin
				res.error = ERR_PAST_END;
			end else begin
				res.disk_op = (item.cmd == BUS_WRITE) ? DOP_WRITE : DOP_READ;
				res.disk_addr = sector_base_q + 32'(byte_count_q);
				if (item.cmd == BUS_WRITE) begin
					res.disk_wdata = item.write_data;
				end
				byte_count_d = count_next;
				// The last word of the sector makes the drive ready again.
				if (count_next >= SectorEnd) begin
					status_d = ST_READY;
					res.irq = item.cmd;
				end
			end
		end else if (item.cmd == BUS_READ && item.offset == PORT_CMD
				&& item.access_size == SIZE_BYTE) begin
			res.read_data = status_q;
		end else if (item.cmd == BUS_WRITE && item.offset >= PORT_COUNT
				&& item.access_size == SIZE_BYTE) begin
			if (item.offset inside {[PORT_LBA0:PORT_LBA3]}) begin
				lba_d[2'(item.offset - PORT_LBA0)] = code;
			end else if (item.offset == PORT_CMD) begin
				// Every command rewinds the transfer to the sector start.
				sector_base_d = sector * SectorMul;
				byte_count_d = '0;
				status_d = code;
				case (code)
					CMD_READ: begin
						write_mode_d = 1'b0;
						status_d = ST_READY;
						res.irq = 1'b1;
					end
					CMD_WRITE: begin
						write_mode_d = 1'b1;
					end
					default: begin
						res.error = ERR_COMMAND;
					end
				endcase
			end
		end else begin
			res.error = ERR_ACCESS;
		end
	end
endmodule

FILE: rtl/ide_pio_disk_controller.sv
// Path: an accepted item is held in the input register, decoded, and its
// result item is captured in the output register.
// Throughput: one bus access per cycle when out_ch is not stalled, set
// by the single decode stage between the input and output registers.
// Reset: arst_n clears the valid flags at once and returns the drive to
// ready status, read mode, sector zero and an empty transfer count.
// ----------------------------------------------------------------------------
// ide_pio_disk_controller
// PIO disk controller: register window, command issue and data word requests.
// ----------------------------------------------------------------------------
module ide_pio_disk_controller #(
	parameter int SECTOR_BYTES = 512
) (
	input logic        clk,
	input logic        arst_n,
	ipdc_chan_if.sink   in_ch,
	ipdc_chan_if.source out_ch
);
	import ipdc_pkg::*;

	localparam int CW = $clog2(SECTOR_BYTES + 4);

	in_item_t        item_s1;
	logic            valid_s1;
	out_item_t       res_s2;
	logic            valid_s2;
	out_item_t       res;
	logic            advance;
	logic            in_accept;

	logic [3:0][7:0] lba_q, lba_d;
	logic [7:0]      status_q, status_d;
	logic            write_mode_q, write_mode_d;
	logic [CW-1:0]   byte_count_q, byte_count_d;
	logic [31:0]     sector_base_q, sector_base_d;

	assign advance   = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_accept = in_ch.valid && in_ch.ready;

	assign out_ch.valid = valid_s2;
	assign out_ch.data  = res_s2;

	ipdc_access #(
		.SECTOR_BYTES(SECTOR_BYTES),
		.CW(CW)
	) u_access (
		.item(item_s1),
		.lba_q(lba_q),
		.status_q(status_q),
		.write_mode_q(write_mode_q),
		.byte_count_q(byte_count_q),
		.sector_base_q(sector_base_q),
		.res(res),
		.lba_d(lba_d),
		.status_d(status_d),
		.write_mode_d(write_mode_d),
		.byte_count_d(byte_count_d),
		.sector_base_d(sector_base_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			lba_q <= '0;
			status_q <= ST_READY;
			write_mode_q <= 1'b0;
			byte_count_q <= '0;
			sector_base_q <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				lba_q <= lba_d;
				status_q <= status_d;
				write_mode_q <= write_mode_d;
				byte_count_q <= byte_count_d;
				sector_base_q <= sector_base_d;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_ch.data;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end
endmodule

FILE: rtl/ipdc_checker.sv
// ----------------------------------------------------------------------------
// ipdc_checker
// Port-level checks on the result channel of the PIO disk controller.
// ----------------------------------------------------------------------------
module ipdc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input ipdc_pkg::out_item_t  out_data
);
	import ipdc_pkg::*;

	// A stalled result item must hold until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// No disk request means no address and no write word.
	a_idle_bus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.disk_op == DOP_NONE |-> out_data.disk_addr == 32'd0
			&& out_data.disk_wdata == 32'd0)
		else $error("address or data without a disk request");

	// Only a write request carries a data word.
	a_wdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.disk_op == DOP_READ |-> out_data.disk_wdata == 32'd0)
		else $error("write data on a read request");

	// A failed access makes no request and raises no interrupt.
	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error != ERR_OK |-> out_data.disk_op == DOP_NONE
			&& !out_data.irq && out_data.read_data == 8'd0)
		else $error("failed access had side effects");

	// A status read is never combined with a data request.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.read_data != 8'd0 |-> out_data.disk_op == DOP_NONE
			&& !out_data.irq)
		else $error("status byte alongside a disk request");
endmodule

bind ide_pio_disk_controller ipdc_checker u_ipdc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data(out_ch.data)
);

FILE: test/ipdc_access_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipdc_access_checker
// Watches both channels of the PIO disk controller, keeps a shadow of the
// drive registers, works out the response to every accepted bus access and
// compares each delivered response against the oldest one still due.
// ----------------------------------------------------------------------------
module ipdc_access_checker #(
	parameter int SECTOR_BYTES = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  ipdc_pkg::in_item_t   in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  ipdc_pkg::out_item_t  out_data,
	output int                   outstanding,
	output int                   fail_count
);
	import ipdc_pkg::*;

	logic [7:0]  lba_shadow [4];
	logic [7:0]  status_shadow;
	logic        write_xfer;
	int          xfer_bytes;
	logic [31:0] sector_base;
	out_item_t   due_q [$];
	out_item_t   want;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (fail_count < 100) begin
			$display("%0t MISMATCH %s: got %h, expected %h", $time, what, got, exp_val);
		end
		fail_count++;
	endtask

	// Applies one bus access to the shadow registers and returns its response.
	function automatic out_item_t decode_access(input in_item_t acc);
		out_item_t   res;
		logic [31:0] sector;
		logic [7:0]  code;
		res = '0;
		res.disk_op = DOP_NONE;
		res.error = ERR_OK;
		code = acc.write_data[7:0];
		if (acc.offset == PORT_DATA && acc.access_size == SIZE_WORD) begin
			if (acc.cmd != write_xfer) begin
				res.error = ERR_DIRECTION;
			end else if (xfer_bytes >= SECTOR_BYTES) begin
				res.error = ERR_PAST_END;
			end else begin
				res.disk_op = (acc.cmd == BUS_WRITE) ? DOP_WRITE : DOP_READ;
				res.disk_addr = sector_base + 32'(xfer_bytes);
				if (acc.cmd == BUS_WRITE) begin
					res.disk_wdata = acc.write_data;
				end
				xfer_bytes += 4;
				if (xfer_bytes >= SECTOR_BYTES) begin
					status_shadow = ST_READY;
					if (acc.cmd == BUS_WRITE) begin
						res.irq = 1'b1;
					end
				end
			end
		end else if (acc.cmd == BUS_READ && acc.offset == PORT_CMD &&
				acc.access_size == SIZE_BYTE) begin
			res.read_data = status_shadow;
		end else if (acc.cmd == BUS_WRITE && acc.offset >= PORT_COUNT &&
				acc.access_size == SIZE_BYTE) begin
			if (acc.offset >= PORT_LBA0 && acc.offset <= PORT_LBA3) begin
				lba_shadow[2'(acc.offset - PORT_LBA0)] = code;
			end else if (acc.offset == PORT_CMD) begin
				// Any command rewinds the transfer to the start of the addressed sector.
				sector = {lba_shadow[3] & TOP_MASK, lba_shadow[2], lba_shadow[1],
					lba_shadow[0]};
				sector_base = sector * 32'(SECTOR_BYTES);
				xfer_bytes = 0;
				status_shadow = code;
				if (code == CMD_READ) begin
					write_xfer = BUS_READ;
					status_shadow = ST_READY;
					res.irq = 1'b1;
				end else if (code == CMD_WRITE) begin
					write_xfer = BUS_WRITE;
				end else begin
					res.error = ERR_COMMAND;
				end
			end
		end else begin
			res.error = ERR_ACCESS;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				lba_shadow[i] = '0;
			end
			status_shadow = ST_READY;
			write_xfer = BUS_READ;
			xfer_bytes = 0;
			sector_base = '0;
			due_q.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_q.size() == 0) begin
					report_mismatch("item with no response due, disk_addr",
						out_data.disk_addr, '0);
				end else begin
					want = due_q.pop_front();
					if (out_data.read_data !== want.read_data) begin
						report_mismatch("read_data", 32'(out_data.read_data), 32'(want.read_data));
					end
					if (out_data.disk_op !== want.disk_op) begin
						report_mismatch("disk_op", 32'(out_data.disk_op), 32'(want.disk_op));
					end
					if (out_data.disk_addr !== want.disk_addr) begin
						report_mismatch("disk_addr", out_data.disk_addr, want.disk_addr);
					end
					if (out_data.disk_wdata !== want.disk_wdata) begin
						report_mismatch("disk_wdata", out_data.disk_wdata, want.disk_wdata);
					end
					if (out_data.irq !== want.irq) begin
						report_mismatch("irq", 32'(out_data.irq), 32'(want.irq));
					end
					if (out_data.error !== want.error) begin
						report_mismatch("error", 32'(out_data.error), 32'(want.error));
					end
				end
			end
			if (in_valid && in_ready) begin
				due_q.push_back(decode_access(in_data));
			end
			outstanding <= due_q.size();
		end
	end

endmodule

FILE: test/tb_ide_pio_disk_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ide_pio_disk_controller
// Drives bus accesses into the PIO disk controller: a directed pass over the
// register window and error cases, then command sequences with random sector
// numbers and data runs, some covering whole sectors, mixed with noise.
// Both sides of the block idle at random; the receiver holds off once long
// enough to back the block up.
// ----------------------------------------------------------------------------
module tb_ide_pio_disk_controller;
	import ipdc_pkg::*;

	localparam int SECTOR_BYTES = 512;
	localparam int ITEMS = 400;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;

	bit   calm = 1'b0;
	bit   lazy_tx = 1'b0;
	int   sent = 0;
	int   quiet_cycles = 0;
	int   outstanding;
	int   fail_count;

	ipdc_chan_if #(.T(in_item_t))  in_ch ();
	ipdc_chan_if #(.T(out_item_t)) out_ch ();

	ide_pio_disk_controller #(.SECTOR_BYTES(SECTOR_BYTES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	ipdc_access_checker #(.SECTOR_BYTES(SECTOR_BYTES)) access_mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_data     (in_ch.data),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_data    (out_ch.data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always #1 clk = ~clk;

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Ends the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic in_item_t bus_access(input logic c, input logic [2:0] off,
			input logic [2:0] sz, input logic [31:0] d);
		in_item_t acc;
		acc.cmd = c;
		acc.offset = off;
		acc.access_size = sz;
		acc.write_data = d;
		return acc;
	endfunction

	task automatic push_access(input in_item_t acc);
		if (!calm && lazy_tx && $urandom_range(0, 2) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= acc;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
		if (sent % 40 == 0) begin
			lazy_tx = $urandom_range(0, 1);
		end
		if (sent >= ITEMS - 60) begin
			calm <= 1'b1;
		end
	endtask

	initial begin : drain
		int n;
		int cyc;
		bit lazy_rx;
		bit squeezed;
		out_ch.ready <= 1'b0;
		cyc = 0;
		lazy_rx = 1'b0;
		squeezed = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		out_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			cyc++;
			if ($urandom_range(0, 47) == 0) begin
				lazy_rx = ~lazy_rx;
			end
			if (!squeezed && cyc >= 300) begin
				// Long hold-off while the sender keeps offering, so the input stalls.
				squeezed = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				cyc += HOLD_CYCLES;
				out_ch.ready <= 1'b1;
			end else if (!calm && lazy_rx && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 7);
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
				cyc += n;
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int         seq;
		int         run;
		int         r;
		logic       dir;
		logic [7:0] code;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		// Register window and error cases from reset.
		push_access(bus_access(BUS_READ, PORT_CMD, SIZE_BYTE, 32'h0));
		push_access(bus_access(BUS_WRITE, PORT_COUNT, SIZE_BYTE, 32'hffff_ffff));
		push_access(bus_access(BUS_READ, PORT_DATA, SIZE_WORD, 32'h0));
		push_access(bus_access(BUS_WRITE, PORT_DATA, SIZE_WORD, 32'h1234_5678));
		push_access(bus_access(BUS_READ, PORT_COUNT, SIZE_BYTE, 32'h0));
		push_access(bus_access(BUS_WRITE, PORT_DATA, SIZE_BYTE, 32'h0));
		push_access(bus_access(BUS_WRITE, 3'd1, SIZE_BYTE, 32'h55));
		push_access(bus_access(BUS_READ, PORT_DATA, 3'd0, 32'h0));
		push_access(bus_access(BUS_WRITE, PORT_CMD, 3'd7, 32'h20));
		push_access(bus_access(BUS_READ, PORT_DATA, 3'd2, 32'h0));
		// Largest sector number: the top byte is masked, the base wraps.
		for (int k = 0; k < 4; k++) begin
			push_access(bus_access(BUS_WRITE, PORT_LBA0 + 3'(k), SIZE_BYTE, 32'hffff_ffff));
		end
		push_access(bus_access(BUS_WRITE, PORT_CMD, SIZE_BYTE, {24'h0, CMD_READ}));
		push_access(bus_access(BUS_READ, PORT_DATA, SIZE_WORD, 32'h0));
		push_access(bus_access(BUS_WRITE, PORT_CMD, SIZE_BYTE, 32'hffff_ff5a));
		push_access(bus_access(BUS_READ, PORT_CMD, SIZE_BYTE, 32'h0));
		push_access(bus_access(BUS_WRITE, PORT_LBA3, SIZE_BYTE, 32'h0000_00e0));
		push_access(bus_access(BUS_WRITE, PORT_CMD, SIZE_BYTE, {24'hffffff, CMD_WRITE}));
		push_access(bus_access(BUS_READ, PORT_CMD, SIZE_BYTE, 32'h0));
		push_access(bus_access(BUS_READ, PORT_DATA, SIZE_WORD, 32'h0));
		push_access(bus_access(BUS_WRITE, PORT_DATA, SIZE_WORD, 32'hffff_ffff));
		push_access(bus_access(BUS_WRITE, PORT_DATA, SIZE_WORD, 32'h0));

		// Command sequences with random sectors and data runs, plus noise.
		// The first two sequences, a write then a read, each issue at least a sector's worth of data word accesses.
		seq = 0;
		dir = BUS_READ;
		while (sent < ITEMS) begin
			if (seq >= 2 && $urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					push_access(bus_access(1'($urandom), 3'($urandom), 3'($urandom), $urandom));
				end
			end else begin
				for (int k = 0; k < 4; k++) begin
					if (seq < 2 || $urandom_range(0, 3) != 0) begin
						push_access(bus_access(BUS_WRITE, PORT_LBA0 + 3'(k), SIZE_BYTE, $urandom));
					end
				end
				r = $urandom_range(0, 9);
				code = (seq == 0) ? CMD_WRITE : (seq == 1) ? CMD_READ :
					(r < 4) ? CMD_READ : (r < 9) ? CMD_WRITE : 8'($urandom);
				if (code == CMD_READ) begin
					dir = BUS_READ;
				end else if (code == CMD_WRITE) begin
					dir = BUS_WRITE;
				end
				push_access(bus_access(BUS_WRITE, PORT_CMD, SIZE_BYTE, {24'($urandom), code}));
				if (seq < 2 || $urandom_range(0, 3) == 0) begin
					run = SECTOR_BYTES / 4 + $urandom_range(0, 3);
				end else begin
					run = $urandom_range(1, 12);
				end
				for (int k = 0; k < run && sent < ITEMS; k++) begin
					if ($urandom_range(0, 7) == 0) begin
						push_access(bus_access(BUS_READ, PORT_CMD, SIZE_BYTE, $urandom));
					end
					push_access(bus_access(($urandom_range(0, 15) == 0) ? ~dir : dir,
						PORT_DATA, SIZE_WORD, $urandom));
				end
				seq++;
			end
		end
		in_ch.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
